// File: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
// Included by the modules that carry assertions; expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked property, gated off while reset is held.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds through reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
package spq_pkg;

  localparam int PRIO_W = 5;
  localparam int ID_W   = 32;
  localparam int OCC_W  = 8;

  // Request opcodes.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t data;
  } cmd_t;

endpackage

// File: rtl/core/spq_req_if.sv
// Request channel of the sorted priority queue: valid/ready plus request fields.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [PRIO_W-1:0] priority_req;
  logic [ID_W-1:0]   item_id;

  modport source (output valid, output op, output priority_req, output item_id,
                  input ready);
  modport sink   (input valid, input op, input priority_req, input item_id,
                  output ready);
endinterface

// File: rtl/core/spq_rsp_if.sv
// Result channel of the sorted priority queue: valid/ready plus result fields.
// Depends on spq_pkg.
interface spq_rsp_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PRIO_W-1:0] out_priority;
  logic [ID_W-1:0]   out_id;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output out_priority, output out_id,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_priority, input out_id,
                  input occupancy, output ready);
endinterface

// File: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell and a result register.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell and the defines header.
//
//   channel | dir | fields
//   --------+-----+-------------------------------------------
//   req     | in  | op, priority_req, item_id
//   rsp     | out | status, out_priority, out_id, occupancy
//
// All cells update together from their neighbors and the broadcast request,
// so a new item is taken each cycle while req.ready is high.
// The result is registered and appears the cycle after acceptance.
// req.ready is low only while a result waits and rsp.ready is low.
// Synchronous reset empties the chain; no clearing pass is needed.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY        = 128,
  parameter int PRIORITY_LEVELS = 16
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t            cell_entry [CAPACITY];
  logic              cell_valid [CAPACITY];
  logic              cell_shift [CAPACITY];
  cmd_t              cmd;
  logic              accept;
  logic              full;
  logic              empty;
  logic [PRIO_W-1:0] prio_sat;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              is_insert;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = cell_valid[CAPACITY-1];
  assign empty     = !cell_valid[0];
  assign is_insert = (req.op == OP_INSERT);

  // Saturate the requested priority into the legal range.
  always_comb begin
    prio_sat = req.priority_req;
    if (req.priority_req == '0) begin
      prio_sat = PRIO_W'(1);
    end else if (int'(req.priority_req) > PRIORITY_LEVELS) begin
      prio_sat = PRIO_W'(PRIORITY_LEVELS);
    end
  end

  // Command broadcast to the chain.
  always_comb begin
    cmd.ins       = accept && is_insert && !full;
    cmd.rem       = accept && !is_insert && !empty;
    cmd.data.prio = prio_sat;
    cmd.data.id   = req.item_id;
  end

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t up_entry;
    logic   up_valid;
    logic   up_shift;
    entry_t dn_entry;
    logic   dn_valid;

    if (i == 0) begin : g_top
      assign up_entry = '1;
      assign up_valid = 1'b1;
      assign up_shift = 1'b0;
    end else begin : g_mid
      assign up_entry = cell_entry[i-1];
      assign up_valid = cell_valid[i-1];
      assign up_shift = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign dn_entry = '0;
      assign dn_valid = 1'b0;
    end else begin : g_inner
      assign dn_entry = cell_entry[i+1];
      assign dn_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .up_entry (up_entry),
      .up_valid (up_valid),
      .up_shift (up_shift),
      .dn_entry (dn_entry),
      .dn_valid (dn_valid),
      .entry    (cell_entry[i]),
      .valid    (cell_valid[i]),
      .shift    (cell_shift[i])
    );
  end

  // Entry count.
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Result payload, captured when an item is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.occupancy    <= OCC_W'(count_next);
      rsp.out_priority <= '0;
      rsp.out_id       <= '0;
      if (is_insert) begin
        rsp.status <= full ? STATUS_FULL : STATUS_OK;
      end else if (empty) begin
        rsp.status <= STATUS_EMPTY;
      end else begin
        rsp.status       <= STATUS_OK;
        rsp.out_priority <= cell_entry[0].prio;
        rsp.out_id       <= cell_entry[0].id;
      end
    end
  end

  // Counter and cell flags agree on emptiness and fullness; FULL results report capacity.
  `SPQ_ASSERT(a_count_empty, (count == '0) == empty, "count disagrees with chain")
  `SPQ_ASSERT(a_count_full, (int'(count) == CAPACITY) == full,
              "count disagrees with full flag")
  `SPQ_ASSERT(a_full_status, (rsp.valid && (rsp.status == STATUS_FULL)) |->
              (int'(rsp.occupancy) == (CAPACITY % 256)), "drop reported below capacity")

endmodule

// File: rtl/core/spq_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"

module spq_cell import spq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  entry_t up_entry,
  input  logic   up_valid,
  input  logic   up_shift,
  input  entry_t dn_entry,
  input  logic   dn_valid,
  output entry_t entry,
  output logic   valid,
  output logic   shift
);

  // The chain is sorted with the highest priority in cell 0. On insert, this
  // cell and everything below it moves down when it is empty or its priority
  // is equal or lower than the new one.
  assign shift = !valid || (entry.prio <= cmd.data.prio);

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      valid <= valid | up_valid;
    end else if (cmd.rem) begin
      valid <= dn_valid;
    end
  end

  // Entry data: take the upper neighbor, the new entry, or the lower neighbor.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (up_shift) begin
        entry <= up_entry;
      end else if (shift) begin
        entry <= cmd.data;
      end
    end else if (cmd.rem) begin
      entry <= dn_entry;
    end
  end

  // Filled cells form an unbroken run from the top, in descending priority.
  `SPQ_ASSERT(a_fill_contiguous, valid |-> up_valid, "cell filled below a gap")
  `SPQ_ASSERT(a_sorted, (valid && up_valid) |-> (up_entry.prio >= entry.prio),
              "chain out of priority order")
  `SPQ_ASSERT(a_prio_nonzero, valid |-> (entry.prio != '0), "stored priority is zero")

endmodule

// File: tb/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed table, then random traffic.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the sorted_priority_queue RTL.
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int CAPACITY = 128;
  localparam int LEVELS   = 16;
  localparam int FILL_LEN = CAPACITY + 8;

  // One result as seen on the response channel.
  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [OCC_W-1:0]  occ;
  } queue_rsp_t;

  // One row of the directed table; rows with known = 1 carry a hand-typed result.
  typedef struct packed {
    op_t               op;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic              known;
    queue_rsp_t        rsp;
  } directed_row_t;

  localparam int NUM_ROWS = 22;
  localparam directed_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    // Remove on an empty queue right after reset.
    '{OP_REMOVE, 5'd31, 32'hFFFF_FFFF, 1'b1, '{STATUS_EMPTY, 5'd0, 32'd0, 8'd0}},
    // Priority zero saturates to one.
    '{OP_INSERT, 5'd0,  32'h0000_0000, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd1}},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b1, '{STATUS_OK, 5'd1, 32'd0, 8'd0}},
    // Priority above the top level saturates to the top level.
    '{OP_INSERT, 5'd31, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd1}},
    '{OP_REMOVE, 5'd7,  32'h1234_5678, 1'b1, '{STATUS_OK, 5'd16, 32'hFFFF_FFFF, 8'd0}},
    // Mixed priorities with ties; the newest of equal priority leaves first.
    '{OP_INSERT, 5'd16, 32'h0000_0001, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd1}},
    '{OP_INSERT, 5'd1,  32'h0000_0002, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd2}},
    '{OP_INSERT, 5'd17, 32'h0000_0003, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd3}},
    '{OP_INSERT, 5'd5,  32'h0000_0004, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd4}},
    '{OP_INSERT, 5'd8,  32'h0000_0005, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd5}},
    '{OP_INSERT, 5'd5,  32'h0000_0006, 1'b1, '{STATUS_OK, 5'd0, 32'd0, 8'd6}},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 5'd31, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 5'd10, 32'hA5A5_A5A5, 1'b0, '0},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 5'd3,  32'h0000_0000, 1'b1, '{STATUS_EMPTY, 5'd0, 32'd0, 8'd0}},
    // Complementary payloads (only the MSB set, only the MSB clear) at equal priority.
    '{OP_INSERT, 5'd2,  32'h8000_0000, 1'b0, '0},
    '{OP_INSERT, 5'd2,  32'h7FFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue #(
    .CAPACITY       (CAPACITY),
    .PRIORITY_LEVELS(LEVELS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the sorted list, ascending priority, top of queue at the end.
  entry_t     sorted_entries [CAPACITY];
  int         stored_count;
  queue_rsp_t awaited_results [$];
  int         mismatch_count = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic queue_rsp_t serve_request(op_t op, logic [PRIO_W-1:0] prio,
                                               logic [ID_W-1:0] id);
    queue_rsp_t        res;
    logic [PRIO_W-1:0] level;
    int                slot;
    res = '{STATUS_OK, '0, '0, '0};
    if (op == OP_INSERT) begin
      if (stored_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        if (prio == 0) level = PRIO_W'(1);
        else if (prio > LEVELS) level = PRIO_W'(LEVELS);
        else level = prio;
        slot = 0;
        while (slot < stored_count && sorted_entries[slot].prio <= level) slot++;
        for (int i = stored_count; i > slot; i--) sorted_entries[i] = sorted_entries[i-1];
        sorted_entries[slot] = '{level, id};
        stored_count++;
      end
    end else begin
      if (stored_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        stored_count--;
        res.prio = sorted_entries[stored_count].prio;
        res.id   = sorted_entries[stored_count].id;
      end
    end
    res.occ = stored_count[OCC_W-1:0];
    return res;
  endfunction

  // Presents one item, waits for it to be taken, and records its expected result.
  task automatic send_item(op_t op, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id,
                           logic known, queue_rsp_t typed_rsp);
    queue_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.priority_req <= prio;
    req_ch.item_id      <= id;
    do @(posedge clk); while (!req_ch.ready);
    predicted = serve_request(op, prio, id);
    awaited_results.push_back(known ? typed_rsp : predicted);
  endtask

  // Mostly in-range priorities, often clustered to force ties, sometimes any field value.
  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(15);
    if (r == 0) return PRIO_W'($urandom_range(31));
    if (r < 4) return PRIO_W'($urandom_range(1, 3));
    return PRIO_W'($urandom_range(1, LEVELS));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(op_t op);
    send_item(op, pick_priority(), pick_id(), 1'b0, '0);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // One idling phase: overfill, drain past empty, then mixed traffic of shifting bias.
  task automatic run_phase(int send_pct, int stall_pct, int mixed_len);
    int insert_pct;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < FILL_LEN; n++) send_random(OP_INSERT);
    for (int n = 0; n < FILL_LEN; n++) send_random(OP_REMOVE);
    for (int n = 0; n < mixed_len; n++) begin
      case ((n / 32) % 3)
        0: insert_pct = 75;
        1: insert_pct = 50;
        default: insert_pct = 25;
      endcase
      send_random(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE);
    end
    wait_for_drain();
  endtask

  // Receiver side: ready drops at random according to the current phase.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every taken result is matched against the oldest expectation.
  always @(posedge clk) begin
    queue_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("Result with no request outstanding: status=%0d occupancy=%0d",
               rsp_ch.status, rsp_ch.occupancy);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, rsp_ch.out_priority);
          mismatch_count++;
        end
        if (rsp_ch.out_id !== want.id) begin
          $error("out_id: expected %h, got %h", want.id, rsp_ch.out_id);
          mismatch_count++;
        end
        if (rsp_ch.occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, rsp_ch.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.op           <= OP_INSERT;
    req_ch.priority_req <= '0;
    req_ch.item_id      <= '0;
    stored_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].prio, DIRECTED_ROWS[r].id,
                DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].rsp);
    end
    wait_for_drain();

    run_phase(0, 0, 110);
    run_phase(65, 0, 110);
    run_phase(0, 65, 110);
    run_phase(28, 28, 110);

    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
